// File: hdl/mpm_pkg.sv
// Shared types and codes for the multi-pattern matcher.
// No dependencies; imported by every module of the block.
package mpm_pkg;

    // Input item actions
    localparam logic [1:0] ACT_PAT = 2'd0;
    localparam logic [1:0] ACT_END = 2'd1;
    localparam logic [1:0] ACT_TXT = 2'd2;
    localparam logic [1:0] ACT_CLR = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_DEEP = 2'd2;
    localparam logic [1:0] ST_MANY = 2'd3;

    // Matches reported per text symbol, and the width of their counter
    localparam int MAX_RESULTS = 32;
    localparam int RCW         = 6;

    typedef struct packed {
        logic [1:0] action;
        logic [2:0] symbol;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [16:0] match_start;
        logic [6:0]  pattern_number;
        logic [7:0]  automaton_state;
        logic        last;
    } t_out;

    // Write enables of the trie store
    typedef struct packed {
        logic child;
        logic info;
        logic leaf;
        logic link;
    } t_mem_we;

endpackage

// File: hdl/mpm_store.sv
// Trie storage: child table, node info, leaf marks and suffix links.
// Depends on mpm_pkg; one write and one registered read port per memory.
module mpm_store #(
    parameter int NODES    = 256,
    parameter int ALPHABET = 5,
    parameter int NW       = 8,
    parameter int CAW      = 11,
    parameter int IW       = 17,
    parameter int LW       = 7
) (
    input  logic             i_clk,
    input  mpm_pkg::t_mem_we i_we,
    input  logic [CAW-1:0]   i_child_waddr,
    input  logic [NW-1:0]    i_child_wdata,
    input  logic [CAW-1:0]   i_child_raddr,
    output logic [NW-1:0]    o_child_rdata,
    input  logic [NW-1:0]    i_node_waddr,
    input  logic [IW-1:0]    i_info_wdata,
    input  logic [LW-1:0]    i_leaf_wdata,
    input  logic [NW-1:0]    i_link_wdata,
    input  logic [NW-1:0]    i_node_raddr,
    output logic [IW-1:0]    o_info_rdata,
    output logic [LW-1:0]    o_leaf_rdata,
    output logic [NW-1:0]    o_link_rdata
);
    import mpm_pkg::*;

    logic [NW-1:0] r_child_mem [NODES*ALPHABET];
    logic [IW-1:0] r_info_mem  [NODES];
    logic [LW-1:0] r_leaf_mem  [NODES];
    logic [NW-1:0] r_link_mem  [NODES];

    always_ff @(posedge i_clk) begin
        if (i_we.child) begin
            r_child_mem[i_child_waddr] <= i_child_wdata;
        end
        o_child_rdata <= r_child_mem[i_child_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.info) begin
            r_info_mem[i_node_waddr] <= i_info_wdata;
        end
        if (i_we.leaf) begin
            r_leaf_mem[i_node_waddr] <= i_leaf_wdata;
        end
        if (i_we.link) begin
            r_link_mem[i_node_waddr] <= i_link_wdata;
        end
        o_info_rdata <= r_info_mem[i_node_raddr];
        o_leaf_rdata <= r_leaf_mem[i_node_raddr];
        o_link_rdata <= r_link_mem[i_node_raddr];
    end

endmodule

// File: hdl/mpm_obuf.sv
// Output register stage between the sequencer and the result channel.
// Depends on mpm_pkg for the result beat type.
module mpm_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpm_pkg::t_out i_push_data,
    output logic          o_can_load,
    output logic          o_valid,
    input  logic          i_ready,
    output mpm_pkg::t_out o_data
);
    import mpm_pkg::*;

    logic r_valid;
    t_out r_data;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_push_data;
        end
    end

endmodule

// File: hdl/multi_pattern_matcher.sv
// Aho-Corasick matcher top level: sequencer plus trie store and output stage.
// Pattern and end items each end in one response beat; a text symbol reads its goto entry,
// follows links on misses, walks the suffix chain and finishes, pausing on result stalls.
// After trie growth the next text symbol first rebuilds every suffix link, scanning each
// node per depth level up to the deepest node and walking link steps, through one port.
// Reset and clear sweep all NODES*ALPHABET child table entries; o_ready is low meanwhile.
module multi_pattern_matcher #(
    parameter int NODES        = 256,
    parameter int ALPHABET     = 5,
    parameter int MAX_DEPTH    = 32,
    parameter int MAX_PATTERNS = 64,
    parameter int TEXT_LEN     = 65536
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  mpm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output mpm_pkg::t_out o_data
);
    import mpm_pkg::*;

    localparam int NW  = $clog2(NODES);
    localparam int CNT = NW + 1;
    localparam int SW  = $clog2(ALPHABET);
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int PNW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PCW = $clog2(MAX_PATTERNS + 1);
    localparam int TW  = $clog2(TEXT_LEN + 1);
    localparam int CAW = $clog2(NODES * ALPHABET);
    localparam int IW  = NW + SW + DW;
    localparam int LW  = 1 + PNW;

    // One-hot sequencer states
    typedef enum logic [15:0] {
        S_CLR    = 16'h0001,
        S_IDLE   = 16'h0002,
        S_INS_RD = 16'h0004,
        S_INS_EV = 16'h0008,
        S_END    = 16'h0010,
        S_RESP   = 16'h0020,
        B_SCAN   = 16'h0040,
        B_INFO   = 16'h0080,
        B_LP     = 16'h0100,
        B_CH     = 16'h0200,
        T_G0     = 16'h0400,
        T_G1     = 16'h0800,
        T_GL     = 16'h1000,
        C_RD     = 16'h2000,
        C_EV     = 16'h4000,
        C_FIN    = 16'h8000
    } t_state;

    t_state r_state, n_state;

    // Automaton bookkeeping
    logic [CNT-1:0] r_node_count, n_node_count;
    logic [NW-1:0]  r_cursor, n_cursor;
    logic [PCW-1:0] r_pat, n_pat;
    logic [NW-1:0]  r_cur, n_cur;
    logic [TW-1:0]  r_pos, n_pos;
    logic [1:0]     r_err, n_err;
    logic           r_links_ok, n_links_ok;
    logic [DW-1:0]  r_max_depth, n_max_depth;

    // Per-item working registers
    logic [SW-1:0]  r_c, n_c;
    logic [1:0]     r_resp_st, n_resp_st;
    logic [CAW-1:0] r_idx, n_idx;
    logic           r_clr_resp, n_clr_resp;
    logic [CNT-1:0] r_x, n_x;
    logic [DW-1:0]  r_d, n_d;
    logic [SW-1:0]  r_s, n_s;
    logic [NW-1:0]  r_u, n_u;
    logic [NW-1:0]  r_v, n_v;
    logic [RCW-1:0] r_n, n_n;
    logic           r_pend_valid, n_pend_valid;
    logic [16:0]    r_pend_start, n_pend_start;
    logic [6:0]     r_pend_num, n_pend_num;

    // Store interface
    t_mem_we        w_we;
    logic [CAW-1:0] w_child_waddr, w_child_raddr;
    logic [NW-1:0]  w_child_wdata, w_child_rd;
    logic [NW-1:0]  w_node_waddr, w_node_raddr;
    logic [IW-1:0]  w_info_wdata, w_info_rd;
    logic [LW-1:0]  w_leaf_wdata, w_leaf_rd;
    logic [NW-1:0]  w_link_wdata, w_link_rd;

    // Output stage interface
    logic           w_push, w_can_load;
    t_out           w_push_data;

    // Decoded store read data and helpers
    logic [NW-1:0]  w_par;
    logic [SW-1:0]  w_psym;
    logic [DW-1:0]  w_depth;
    logic           w_leaf;
    logic [PNW-1:0] w_num;
    logic [SW-1:0]  w_in_c;
    logic [16:0]    w_start;
    logic           w_hit;
    logic           w_adv;

    assign w_par   = w_info_rd[IW-1 -: NW];
    assign w_psym  = w_info_rd[DW +: SW];
    assign w_depth = w_info_rd[DW-1:0];
    assign w_leaf  = w_leaf_rd[PNW];
    assign w_num   = w_leaf_rd[PNW-1:0];

    // Out-of-range symbols fold to symbol 0
    assign w_in_c = (32'(i_data.symbol) < ALPHABET) ? SW'(i_data.symbol) : '0;

    // Start of a match ending at the current position; clamp to 0 below 1
    assign w_start = (32'(w_depth) > 32'(r_pos)) ? 17'd0
                   : 17'(r_pos - TW'(w_depth) + TW'(1));
    assign w_hit   = w_leaf && (r_n < RCW'(MAX_RESULTS));

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_cursor     = r_cursor;
        n_pat        = r_pat;
        n_cur        = r_cur;
        n_pos        = r_pos;
        n_err        = r_err;
        n_links_ok   = r_links_ok;
        n_max_depth  = r_max_depth;
        n_c          = r_c;
        n_resp_st    = r_resp_st;
        n_idx        = r_idx;
        n_clr_resp   = r_clr_resp;
        n_x          = r_x;
        n_d          = r_d;
        n_s          = r_s;
        n_u          = r_u;
        n_v          = r_v;
        n_n          = r_n;
        n_pend_valid = r_pend_valid;
        n_pend_start = r_pend_start;
        n_pend_num   = r_pend_num;

        w_we          = '0;
        w_child_waddr = '0;
        w_child_wdata = '0;
        w_child_raddr = '0;
        w_node_waddr  = '0;
        w_info_wdata  = '0;
        w_leaf_wdata  = '0;
        w_link_wdata  = '0;
        w_node_raddr  = '0;
        w_push        = 1'b0;
        w_push_data   = '0;
        w_adv         = 1'b0;

        case (r_state)
            // Sweep the child table; the node memories ride along for the low entries
            S_CLR: begin
                w_we.child    = 1'b1;
                w_child_waddr = r_idx;
                if (32'(r_idx) < NODES) begin
                    w_we.info    = 1'b1;
                    w_we.leaf    = 1'b1;
                    w_we.link    = 1'b1;
                    w_node_waddr = NW'(r_idx);
                end
                if (r_idx == CAW'(NODES * ALPHABET - 1)) begin
                    n_resp_st = ST_OK;
                    n_state   = r_clr_resp ? S_RESP : S_IDLE;
                end else begin
                    n_idx = r_idx + CAW'(1);
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_c   = w_in_c;
                    case (i_data.action)
                        ACT_PAT: begin
                            if (r_err != ST_OK) begin
                                n_resp_st = r_err;
                                n_state   = S_RESP;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_END: begin
                            n_state = S_END;
                        end
                        ACT_TXT: begin
                            if (r_links_ok || r_node_count == CNT'(1)) begin
                                n_u     = r_cur;
                                n_state = T_G0;
                            end else begin
                                n_x     = CNT'(1);
                                n_d     = DW'(1);
                                n_state = B_SCAN;
                            end
                        end
                        ACT_CLR: begin
                            n_node_count = CNT'(1);
                            n_cursor     = '0;
                            n_pat        = '0;
                            n_cur        = '0;
                            n_pos        = '0;
                            n_err        = ST_OK;
                            n_links_ok   = 1'b0;
                            n_max_depth  = '0;
                            n_idx        = '0;
                            n_clr_resp   = 1'b1;
                            n_state      = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_RD: begin
                w_child_raddr = CAW'(r_cursor) * CAW'(ALPHABET) + CAW'(r_c);
                w_node_raddr  = r_cursor;
                n_state       = S_INS_EV;
            end

            S_INS_EV: begin
                if (32'(w_depth) >= MAX_DEPTH) begin
                    n_err = ST_DEEP;
                end else if (w_child_rd != '0) begin
                    n_cursor = w_child_rd;
                end else if (32'(r_node_count) >= NODES) begin
                    n_err = ST_FULL;
                end else begin
                    // Grow a node and drop every computed link
                    w_we.child    = 1'b1;
                    w_child_waddr = CAW'(r_cursor) * CAW'(ALPHABET) + CAW'(r_c);
                    w_child_wdata = NW'(r_node_count);
                    w_we.info     = 1'b1;
                    w_we.leaf     = 1'b1;
                    w_node_waddr  = NW'(r_node_count);
                    w_info_wdata  = {r_cursor, r_c, w_depth + DW'(1)};
                    w_leaf_wdata  = '0;
                    n_node_count  = r_node_count + CNT'(1);
                    n_links_ok    = 1'b0;
                    n_cursor      = NW'(r_node_count);
                    if (w_depth + DW'(1) > r_max_depth) begin
                        n_max_depth = w_depth + DW'(1);
                    end
                end
                n_resp_st = n_err;
                n_state   = S_RESP;
            end

            S_END: begin
                n_resp_st = r_err;
                if (r_err == ST_OK) begin
                    if (32'(r_pat) >= MAX_PATTERNS) begin
                        n_resp_st = ST_MANY;
                    end else begin
                        w_we.leaf    = 1'b1;
                        w_node_waddr = r_cursor;
                        w_leaf_wdata = {1'b1, PNW'(r_pat)};
                        n_pat        = r_pat + PCW'(1);
                    end
                end
                n_err    = ST_OK;
                n_cursor = '0;
                n_state  = S_RESP;
            end

            S_RESP: begin
                if (w_can_load) begin
                    w_push                      = 1'b1;
                    w_push_data.status          = r_resp_st;
                    w_push_data.automaton_state = 8'(r_cur);
                    w_push_data.last            = 1'b1;
                    n_state                     = S_IDLE;
                end
            end

            // Link rebuild, shallow nodes first
            B_SCAN: begin
                w_node_raddr = NW'(r_x);
                n_state      = B_INFO;
            end

            B_INFO: begin
                if (w_depth != r_d) begin
                    w_adv = 1'b1;
                end else if (w_par == '0) begin
                    w_we.link    = 1'b1;
                    w_node_waddr = NW'(r_x);
                    w_link_wdata = '0;
                    w_adv        = 1'b1;
                end else begin
                    w_node_raddr = w_par;
                    n_s          = w_psym;
                    n_state      = B_LP;
                end
            end

            B_LP: begin
                n_u           = w_link_rd;
                w_child_raddr = CAW'(w_link_rd) * CAW'(ALPHABET) + CAW'(r_s);
                n_state       = B_CH;
            end

            B_CH: begin
                if (w_child_rd != '0 || r_u == '0) begin
                    w_we.link    = 1'b1;
                    w_node_waddr = NW'(r_x);
                    w_link_wdata = w_child_rd;
                    w_adv        = 1'b1;
                end else begin
                    w_node_raddr = r_u;
                    n_state      = B_LP;
                end
            end

            // Goto step of the text symbol
            T_G0: begin
                w_child_raddr = CAW'(r_u) * CAW'(ALPHABET) + CAW'(r_c);
                n_state       = T_G1;
            end

            T_G1: begin
                if (w_child_rd != '0 || r_u == '0) begin
                    n_cur        = w_child_rd;
                    n_v          = w_child_rd;
                    n_n          = '0;
                    n_pend_valid = 1'b0;
                    if (32'(r_pos) < TEXT_LEN) begin
                        n_pos = r_pos + TW'(1);
                    end
                    n_state = C_RD;
                end else begin
                    w_node_raddr = r_u;
                    n_state      = T_GL;
                end
            end

            T_GL: begin
                n_u     = w_link_rd;
                n_state = T_G0;
            end

            // Suffix chain walk; one match is held back to mark the last beat
            C_RD: begin
                if (r_v == '0) begin
                    n_state = C_FIN;
                end else begin
                    w_node_raddr = r_v;
                    n_state      = C_EV;
                end
            end

            C_EV: begin
                w_node_raddr = r_v;
                if (!(w_hit && r_pend_valid && !w_can_load)) begin
                    if (w_hit) begin
                        if (r_pend_valid) begin
                            w_push                      = 1'b1;
                            w_push_data.status          = ST_OK;
                            w_push_data.found           = 1'b1;
                            w_push_data.match_start     = r_pend_start;
                            w_push_data.pattern_number  = r_pend_num;
                            w_push_data.automaton_state = 8'(r_cur);
                        end
                        n_pend_valid = 1'b1;
                        n_pend_start = w_start;
                        n_pend_num   = 7'(w_num) + 7'd1;
                        n_n          = r_n + RCW'(1);
                    end
                    n_v     = w_link_rd;
                    n_state = C_RD;
                end
            end

            C_FIN: begin
                if (w_can_load) begin
                    w_push                      = 1'b1;
                    w_push_data.status          = ST_OK;
                    w_push_data.found           = r_pend_valid;
                    w_push_data.match_start     = r_pend_valid ? r_pend_start : 17'd0;
                    w_push_data.pattern_number  = r_pend_valid ? r_pend_num : 7'd0;
                    w_push_data.automaton_state = 8'(r_cur);
                    w_push_data.last            = 1'b1;
                    n_state                     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance the rebuild scan: next node, next depth, or done
        if (w_adv) begin
            if (r_x + CNT'(1) == r_node_count) begin
                if (r_d == r_max_depth) begin
                    n_links_ok = 1'b1;
                    n_u        = r_cur;
                    n_state    = T_G0;
                end else begin
                    n_d     = r_d + DW'(1);
                    n_x     = CNT'(1);
                    n_state = B_SCAN;
                end
            end else begin
                n_x     = r_x + CNT'(1);
                n_state = B_SCAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_node_count <= CNT'(1);
            r_cursor     <= '0;
            r_pat        <= '0;
            r_cur        <= '0;
            r_pos        <= '0;
            r_err        <= ST_OK;
            r_links_ok   <= 1'b0;
            r_max_depth  <= '0;
            r_idx        <= '0;
            r_clr_resp   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_n          <= '0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_cursor     <= n_cursor;
            r_pat        <= n_pat;
            r_cur        <= n_cur;
            r_pos        <= n_pos;
            r_err        <= n_err;
            r_links_ok   <= n_links_ok;
            r_max_depth  <= n_max_depth;
            r_idx        <= n_idx;
            r_clr_resp   <= n_clr_resp;
            r_pend_valid <= n_pend_valid;
            r_n          <= n_n;
        end
    end

    // Working payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_c          <= n_c;
        r_resp_st    <= n_resp_st;
        r_x          <= n_x;
        r_d          <= n_d;
        r_s          <= n_s;
        r_u          <= n_u;
        r_v          <= n_v;
        r_pend_start <= n_pend_start;
        r_pend_num   <= n_pend_num;
    end

    mpm_store #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET),
        .NW       (NW),
        .CAW      (CAW),
        .IW       (IW),
        .LW       (LW)
    ) u_store (
        .i_clk         (i_clk),
        .i_we          (w_we),
        .i_child_waddr (w_child_waddr),
        .i_child_wdata (w_child_wdata),
        .i_child_raddr (w_child_raddr),
        .o_child_rdata (w_child_rd),
        .i_node_waddr  (w_node_waddr),
        .i_info_wdata  (w_info_wdata),
        .i_leaf_wdata  (w_leaf_wdata),
        .i_link_wdata  (w_link_wdata),
        .i_node_raddr  (w_node_raddr),
        .o_info_rdata  (w_info_rd),
        .o_leaf_rdata  (w_leaf_rd),
        .o_link_rdata  (w_link_rd)
    );

    mpm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_can_load  (w_can_load),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// File: hdl/mpm_checker.sv
// Port-level checks for the multi-pattern matcher, bound to the top level.
// Depends on mpm_pkg for the beat types.
module mpm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input mpm_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input mpm_pkg::t_out o_data
);
    import mpm_pkg::*;

    // No result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    // One item at a time: the input side closes after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while busy");

    // A match beat carries ok status and a nonzero pattern number
    a_match_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.found |-> o_data.status == ST_OK && o_data.pattern_number != 7'd0)
        else $error("bad match beat");

    // A beat without a match reports no position or pattern and ends its item
    a_nomatch_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.found |->
            o_data.match_start == 17'd0 && o_data.pattern_number == 7'd0 && o_data.last)
        else $error("bad no-match beat");

endmodule

bind multi_pattern_matcher mpm_checker u_mpm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// File: test/tb_multi_pattern_matcher.sv
// Self-checking testbench for multi_pattern_matcher (Aho-Corasick matcher).
// Needs only mpm_pkg and the RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

import mpm_pkg::*;

class match_scoreboard;
    localparam int NN = 256;
    localparam int AB = 5;

    int    child [NN*AB];
    int    goto_memo [NN*AB];
    int    link_memo [NN];
    int    parent [NN];
    int    psym [NN];
    bit    leaf [NN];
    int    pnum [NN];
    int    depth [NN];
    int    node_total, cursor, pat_total, cur_node, text_pos, ins_err;
    t_out  pending_q [$];
    int    errors;
    int    matches_seen;

    function void clear_trie();
        foreach (child[k]) begin
            child[k]     = -1;
            goto_memo[k] = -1;
        end
        foreach (link_memo[k]) begin
            link_memo[k] = -1;
            leaf[k]      = 0;
            depth[k]     = 0;
        end
        node_total = 1;
        cursor     = 0;
        pat_total  = 0;
        cur_node   = 0;
        text_pos   = 0;
        ins_err    = ST_OK;
    endfunction

    function new();
        errors       = 0;
        matches_seen = 0;
        clear_trie();
    endfunction

    function int suffix_of(int v);
        if (link_memo[v] < 0) begin
            if (v == 0 || parent[v] == 0) link_memo[v] = 0;
            else link_memo[v] = step_of(suffix_of(parent[v]), psym[v]);
        end
        return link_memo[v];
    endfunction

    function int step_of(int v, int c);
        int k;
        k = v*AB + c;
        if (goto_memo[k] < 0) begin
            if (child[k] >= 0) goto_memo[k] = child[k];
            else if (v == 0) goto_memo[k] = 0;
            else goto_memo[k] = step_of(suffix_of(v), c);
        end
        return goto_memo[k];
    endfunction

    function void push(logic [1:0] st, bit fd, int start, int num, bit lst);
        t_out r;
        r.status          = st;
        r.found           = fd;
        r.match_start     = start[16:0];
        r.pattern_number  = num[6:0];
        r.automaton_state = cur_node[7:0];
        r.last            = lst;
        pending_q.insert(pending_q.size(), r);
    endfunction

    // Note one accepted input beat and queue the result beats it causes.
    function void note_input(t_in d);
        int c, k, n, v, cnt, start;
        c = (d.symbol < AB) ? int'(d.symbol) : 0;
        case (d.action)
            ACT_CLR: begin
                clear_trie();
                push(ST_OK, 0, 0, 0, 1);
            end
            ACT_PAT: begin
                if (ins_err == ST_OK) begin
                    k = cursor*AB + c;
                    if (depth[cursor] >= 32) ins_err = ST_DEEP;
                    else if (child[k] >= 0) cursor = child[k];
                    else if (node_total >= NN) ins_err = ST_FULL;
                    else begin
                        n = node_total;
                        node_total++;
                        parent[n] = cursor;
                        psym[n]   = c;
                        depth[n]  = depth[cursor] + 1;
                        leaf[n]   = 0;
                        for (int s = 0; s < AB; s++) child[n*AB+s] = -1;
                        child[k] = n;
                        foreach (goto_memo[j]) goto_memo[j] = -1;
                        foreach (link_memo[j]) link_memo[j] = -1;
                        cursor = n;
                    end
                end
                push(ins_err[1:0], 0, 0, 0, 1);
            end
            ACT_END: begin
                int st;
                st = ins_err;
                if (st == ST_OK) begin
                    if (pat_total >= 64) st = ST_MANY;
                    else begin
                        leaf[cursor] = 1;
                        pnum[cursor] = pat_total;
                        pat_total++;
                    end
                end
                ins_err = ST_OK;
                cursor  = 0;
                push(st[1:0], 0, 0, 0, 1);
            end
            default: begin
                cur_node = step_of(cur_node, c);
                if (text_pos < 65536) text_pos++;
                cnt = 0;
                for (v = cur_node; v != 0; v = suffix_of(v)) begin
                    if (leaf[v] && cnt < MAX_RESULTS) begin
                        start = (depth[v] > text_pos) ? 0 : text_pos - depth[v] + 1;
                        push(ST_OK, 1, start, pnum[v] + 1, 0);
                        cnt++;
                    end
                end
                if (cnt == 0) push(ST_OK, 0, 0, 0, 1);
                else pending_q[$].last = 1;
                matches_seen += cnt;
            end
        endcase
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(t_out got);
        t_out exp_r;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat %p", $time, got);
            errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        if (got.status !== exp_r.status) begin
            $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
            errors++;
        end
        if (got.found !== exp_r.found) begin
            $display("%0t: found exp %0d got %0d", $time, exp_r.found, got.found);
            errors++;
        end
        if (got.match_start !== exp_r.match_start) begin
            $display("%0t: match_start exp %0d got %0d", $time,
                     exp_r.match_start, got.match_start);
            errors++;
        end
        if (got.pattern_number !== exp_r.pattern_number) begin
            $display("%0t: pattern_number exp %0d got %0d", $time,
                     exp_r.pattern_number, got.pattern_number);
            errors++;
        end
        if (got.automaton_state !== exp_r.automaton_state) begin
            $display("%0t: automaton_state exp %0d got %0d", $time,
                     exp_r.automaton_state, got.automaton_state);
            errors++;
        end
        if (got.last !== exp_r.last) begin
            $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_multi_pattern_matcher;

    // Idle cycles with no beat on either side before the run is declared hung.
    // A text symbol after trie growth first rebuilds all links; the limit allows for that.
    localparam int HANG_LIMIT = 200000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    match_scoreboard sb;
    int burst_left;
    int items_sent;
    int idle_cycles = 0;
    int stall_phase = 0;

    multi_pattern_matcher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: check each result beat, then pick the next ready level.
    // Alternate stretches of full throughput, light stalls and heavy stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
        stall_phase <= (stall_phase + 1) % 600;
        if (stall_phase < 200) begin
            i_ready <= 1'b1;
        end else if (stall_phase < 400) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("multi_pattern_matcher verification failed");
            $finish;
        end
    end

    // Send one input beat. Work in bursts; drop valid only when a gap starts,
    // so valid stays high across back-to-back beats.
    task automatic send_beat(input logic [1:0] act, input logic [2:0] sym);
        t_in d;
        d.action = act;
        d.symbol = sym;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(d);
        burst_left--;
        items_sent++;
    endtask

    // Hold the sender until every expected result beat has arrived.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_pattern(input int len, input int sym_hi);
        for (int j = 0; j < len; j++) send_beat(ACT_PAT, 3'($urandom_range(0, sym_hi)));
        send_beat(ACT_END, 3'($urandom_range(0, 7)));
    endtask

    initial begin
        int sym_hi;
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        burst_left  = 0;
        items_sent  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: overlapping patterns, duplicate, empty pattern, stray symbols.
        send_beat(ACT_TXT, 3'd0);                   // text on an empty trie
        send_beat(ACT_PAT, 3'd0); send_beat(ACT_PAT, 3'd1); send_beat(ACT_PAT, 3'd2);
        send_beat(ACT_END, 3'd7);
        send_beat(ACT_PAT, 3'd1); send_beat(ACT_PAT, 3'd2); send_beat(ACT_END, 3'd0);
        send_beat(ACT_PAT, 3'd2); send_beat(ACT_END, 3'd0);
        send_beat(ACT_PAT, 3'd0); send_beat(ACT_PAT, 3'd1); send_beat(ACT_PAT, 3'd2);
        send_beat(ACT_END, 3'd0);                   // duplicate renumbers the node
        send_beat(ACT_END, 3'd0);                   // empty pattern marks the root
        send_beat(ACT_PAT, 3'd7); send_beat(ACT_END, 3'd0); // out-of-range symbol -> A
        drain();
        send_beat(ACT_TXT, 3'd0); send_beat(ACT_TXT, 3'd1); send_beat(ACT_TXT, 3'd2);
        send_beat(ACT_TXT, 3'd3); send_beat(ACT_TXT, 3'd4); send_beat(ACT_TXT, 3'd6);
        send_beat(ACT_TXT, 3'd5); send_beat(ACT_CLR, 3'd3);

        // Pattern too deep: 34 symbols on one chain, the 33rd hits the limit,
        // then an error-ending end.
        for (int j = 0; j < 34; j++) send_beat(ACT_PAT, 3'd3);
        send_beat(ACT_END, 3'd0);
        send_beat(ACT_TXT, 3'd3);
        drain();

        // Too many patterns: 66 empty patterns exceed the limit of 64 patterns.
        send_beat(ACT_CLR, 3'd0);
        for (int j = 0; j < 66; j++) send_beat(ACT_END, 3'd0);
        send_beat(ACT_TXT, 3'd1);
        drain();

        // Random phases: build a small dictionary, pause, then stream text.
        while (items_sent < 200) begin
            if ($urandom_range(0, 2) != 0) send_beat(ACT_CLR, 3'($urandom_range(0, 7)));
            sym_hi = ($urandom_range(0, 3) == 0) ? 7 : 2;
            repeat ($urandom_range(1, 5)) send_pattern($urandom_range(0, 6), sym_hi);
            if ($urandom_range(0, 4) == 0) begin
                send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            end
            drain();
            repeat ($urandom_range(15, 40)) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_beat(ACT_END, 3'($urandom_range(0, 7)));
                end else begin
                    send_beat(ACT_TXT, 3'($urandom_range(0, sym_hi)));
                end
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d input beats; %0d matches predicted, incl. deep and",
                 items_sent, sb.matches_seen);
        $display("too-many-pattern errors, duplicates, empty patterns and clears.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("multi_pattern_matcher verification clean");
        end else begin
            $display("multi_pattern_matcher verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mpm_pkg.sv
hdl/mpm_store.sv
hdl/mpm_obuf.sv
hdl/multi_pattern_matcher.sv
hdl/mpm_checker.sv
test/tb_multi_pattern_matcher.sv
